FILE: sv/uerc_pkg.sv
`timescale 1ns / 1ps

package uerc_pkg;

    localparam int RING_ENTRIES   = 64;
    localparam int SLOT_COUNT     = 32;
    localparam int ENDPOINT_COUNT = 8;

    localparam int RI_W     = $clog2(RING_ENTRIES);
    localparam int CNT_DEPTH = SLOT_COUNT * ENDPOINT_COUNT;
    localparam int CNT_AW   = $clog2(CNT_DEPTH);
    localparam int CNT_W    = 32;
    localparam int KEY_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [5:0] TYPE_TRANSFER = 6'd32;
    localparam logic [5:0] TYPE_COMMAND  = 6'd33;
    localparam logic [5:0] TYPE_PORT     = 6'd34;

    localparam logic [7:0] CODE_SUCCESS = 8'd1;
    localparam logic [7:0] CODE_SHORT   = 8'd13;

    localparam logic [2:0] KIND_EMPTY   = 3'd0;
    localparam logic [2:0] KIND_COMMAND = 3'd1;
    localparam logic [2:0] KIND_XFER    = 3'd2;
    localparam logic [2:0] KIND_XFER_OOR = 3'd3;
    localparam logic [2:0] KIND_PORT    = 3'd4;
    localparam logic [2:0] KIND_OTHER   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE = 1'd1;

    typedef struct packed {
        logic        entry_cycle;
        logic [5:0]  entry_type;
        logic [7:0]  completion_code;
        logic [7:0]  slot_id;
        logic [4:0]  endpoint_index;
        logic [23:0] residual_length;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [5:0]  dequeue_index;
        logic        cycle_after;
        logic [7:0]  code_out;
        logic [7:0]  event_slot;
        logic [4:0]  endpoint_out;
        logic [31:0] done_count;
        logic        report_valid;
        logic [23:0] report_length;
    } t_out_beat;

endpackage

FILE: sv/usb_event_ring_consumer.sv
`timescale 1ns / 1ps

// channel | direction | handshake                  | beat
// --------+-----------+----------------------------+------------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_beat)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_beat)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One beat per cycle unless the output stalls; path: input stage, then output register.
// Counter RAM read is issued on accept, write happens as the beat leaves stage 1;
// a same-cycle write to the read address is forwarded.
// Reset: index 0, expected cycle 1, all counters read as zero via per-entry valid bits.
// An output stall holds the output register; the input stalls only when both stages are full.

module usb_event_ring_consumer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  uerc_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output uerc_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [uerc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                             i_cfg_data
);

    logic                              r_blk_en;
    logic                              r_rpt_en;
    logic [uerc_pkg::RI_W-1:0]         r_read_index;
    logic                              r_exp_cycle;
    logic                              r_cnt_vld [uerc_pkg::CNT_DEPTH];

    logic                              r_s1_vld;
    uerc_pkg::t_in_beat                r_s1;
    logic [uerc_pkg::CNT_AW-1:0]       r_s1_addr;
    logic                              r_s1_hit;
    logic [uerc_pkg::CNT_W-1:0]        r_s1_fwd;
    logic                              r_s1_vbit;

    logic                              r_out_vld;
    uerc_pkg::t_out_beat               r_out;

    logic                              out_free;
    logic                              s1_adv;
    logic                              in_acc;
    logic [uerc_pkg::KEY_W-1:0]        in_key;
    logic [uerc_pkg::CNT_AW-1:0]       in_addr;
    logic [uerc_pkg::CNT_W-1:0]        ram_rdata;

    logic                              consume;
    logic                              in_range;
    logic                              is_xfer;
    logic                              cnt_we;
    logic [uerc_pkg::CNT_W-1:0]        cnt_old;
    logic [uerc_pkg::CNT_W-1:0]        cnt_new;
    logic [uerc_pkg::RI_W-1:0]         n_read_index;
    logic                              n_exp_cycle;
    logic [31:0]                       ri_ext;
    uerc_pkg::t_out_beat               n_out;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign s1_adv      = r_s1_vld && out_free;
    assign o_in_stall  = r_s1_vld && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign in_key  = uerc_pkg::KEY_W'(i_in_data.slot_id) * uerc_pkg::KEY_W'(uerc_pkg::ENDPOINT_COUNT)
                   + uerc_pkg::KEY_W'(i_in_data.endpoint_index);
    assign in_addr = in_key[uerc_pkg::CNT_AW-1:0];

    uerc_ram #(
        .WIDTH (uerc_pkg::CNT_W),
        .DEPTH (uerc_pkg::CNT_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_s1_addr),
        .i_wdata (cnt_new),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        consume  = r_blk_en && (r_s1.entry_cycle == r_exp_cycle);
        is_xfer  = (r_s1.entry_type == uerc_pkg::TYPE_TRANSFER);
        in_range = ({1'b0, r_s1.slot_id} < 9'(uerc_pkg::SLOT_COUNT))
                && ({1'b0, r_s1.endpoint_index} < 6'(uerc_pkg::ENDPOINT_COUNT));
        cnt_we   = s1_adv && consume && is_xfer && in_range;
        cnt_old  = r_s1_hit ? r_s1_fwd : (r_s1_vbit ? ram_rdata : '0);
        cnt_new  = cnt_old + 1'b1;

        n_read_index = r_read_index;
        n_exp_cycle  = r_exp_cycle;
        if (consume) begin
            if (r_read_index == uerc_pkg::RI_W'(uerc_pkg::RING_ENTRIES - 1)) begin
                n_read_index = '0;
                n_exp_cycle  = !r_exp_cycle;
            end else begin
                n_read_index = r_read_index + 1'b1;
            end
        end
        ri_ext = 32'(n_read_index);

        n_out = '0;
        n_out.dequeue_index = ri_ext[5:0];
        n_out.cycle_after   = n_exp_cycle;
        n_out.event_kind    = uerc_pkg::KIND_EMPTY;
        if (consume) begin
            n_out.code_out   = r_s1.completion_code;
            n_out.event_slot = r_s1.slot_id;
            if (r_s1.entry_type == uerc_pkg::TYPE_COMMAND) begin
                n_out.event_kind = uerc_pkg::KIND_COMMAND;
            end else if (is_xfer) begin
                n_out.endpoint_out = r_s1.endpoint_index;
                if (in_range) begin
                    n_out.event_kind = uerc_pkg::KIND_XFER;
                    n_out.done_count = cnt_new;
                    if (r_rpt_en && (r_s1.endpoint_index > 5'd1)
                        && (r_s1.completion_code == uerc_pkg::CODE_SUCCESS
                            || r_s1.completion_code == uerc_pkg::CODE_SHORT)) begin
                        n_out.report_valid  = 1'b1;
                        n_out.report_length = r_s1.residual_length;
                    end
                end else begin
                    n_out.event_kind = uerc_pkg::KIND_XFER_OOR;
                end
            end else if (r_s1.entry_type == uerc_pkg::TYPE_PORT) begin
                n_out.event_kind = uerc_pkg::KIND_PORT;
            end else begin
                n_out.event_kind = uerc_pkg::KIND_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_en     <= 1'b0;
            r_rpt_en     <= 1'b0;
            r_read_index <= '0;
            r_exp_cycle  <= 1'b1;
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            for (int i = 0; i < uerc_pkg::CNT_DEPTH; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    uerc_pkg::REG_BLOCK_ENABLED: r_blk_en <= i_cfg_data;
                    uerc_pkg::REG_REPORT_ENABLE: r_rpt_en <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld    <= 1'b1;
                r_read_index <= n_read_index;
                r_exp_cycle  <= n_exp_cycle;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (cnt_we) begin
                r_cnt_vld[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1      <= i_in_data;
            r_s1_addr <= in_addr;
            r_s1_hit  <= cnt_we && (r_s1_addr == in_addr);
            r_s1_fwd  <= cnt_new;
            r_s1_vbit <= r_cnt_vld[in_addr];
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_we_gives_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |=> (o_out_valid && o_out_data.event_kind == uerc_pkg::KIND_XFER))
        else $error("counter write without transfer result");

    a_report_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.report_valid) |->
            (o_out_data.event_kind == uerc_pkg::KIND_XFER && o_out_data.endpoint_out > 5'd1))
        else $error("report on non-qualifying event");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_kind == uerc_pkg::KIND_EMPTY) |->
            (o_out_data.done_count == '0 && !o_out_data.report_valid
             && o_out_data.code_out == '0))
        else $error("empty ring result carries payload");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && r_s1_vld))
        else $error("input stalled with free space");
`endif

endmodule

FILE: sv/uerc_ram.sv
`timescale 1ns / 1ps

module uerc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/sv/usb_event_ring_consumer_chk.sv
`timescale 1ns / 1ps

module usb_event_ring_consumer_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  uerc_pkg::t_in_beat             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  uerc_pkg::t_out_beat            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [uerc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    uerc_pkg::t_out_beat        expected_results[$];
    logic [uerc_pkg::CNT_W-1:0] done_counts [uerc_pkg::CNT_DEPTH];
    int                         rd_pos;
    logic                       want_cycle;
    logic                       ring_on;
    logic                       report_on;

    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result beat %0d %s got 0x%0h want 0x%0h",
                                      o_checked, name, got, want));
        end
    endtask

    function automatic uerc_pkg::t_out_beat consume_entry(uerc_pkg::t_in_beat e);
        uerc_pkg::t_out_beat r;
        int                  k;
        r = '0;
        if (ring_on && e.entry_cycle == want_cycle) begin
            r.code_out   = e.completion_code;
            r.event_slot = e.slot_id;
            case (e.entry_type)
                uerc_pkg::TYPE_COMMAND: begin
                    r.event_kind = uerc_pkg::KIND_COMMAND;
                end
                uerc_pkg::TYPE_TRANSFER: begin
                    r.endpoint_out = e.endpoint_index;
                    if (e.slot_id < uerc_pkg::SLOT_COUNT &&
                        e.endpoint_index < uerc_pkg::ENDPOINT_COUNT) begin
                        k = int'(e.slot_id) * uerc_pkg::ENDPOINT_COUNT
                          + int'(e.endpoint_index);
                        r.event_kind   = uerc_pkg::KIND_XFER;
                        done_counts[k] = done_counts[k] + 32'd1;
                        r.done_count   = done_counts[k];
                        if (report_on && e.endpoint_index > 5'd1 &&
                            (e.completion_code == uerc_pkg::CODE_SUCCESS ||
                             e.completion_code == uerc_pkg::CODE_SHORT)) begin
                            r.report_valid  = 1'b1;
                            r.report_length = e.residual_length;
                        end
                    end else begin
                        r.event_kind = uerc_pkg::KIND_XFER_OOR;
                    end
                end
                uerc_pkg::TYPE_PORT: begin
                    r.event_kind = uerc_pkg::KIND_PORT;
                end
                default: begin
                    r.event_kind = uerc_pkg::KIND_OTHER;
                end
            endcase
            rd_pos++;
            if (rd_pos >= uerc_pkg::RING_ENTRIES) begin
                rd_pos     = 0;
                want_cycle = ~want_cycle;
            end
        end else begin
            r.event_kind = uerc_pkg::KIND_EMPTY;
        end
        r.dequeue_index = 6'(rd_pos);
        r.cycle_after   = want_cycle;
        return r;
    endfunction

    always @(posedge i_clk) begin
        uerc_pkg::t_out_beat want;
        if (!i_rst_n) begin
            expected_results.delete();
            for (int k = 0; k < uerc_pkg::CNT_DEPTH; k++) begin
                done_counts[k] = '0;
            end
            rd_pos       = 0;
            want_cycle   = 1'b1;
            ring_on      = 1'b0;
            report_on    = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    uerc_pkg::REG_BLOCK_ENABLED: ring_on   = i_cfg_data;
                    uerc_pkg::REG_REPORT_ENABLE: report_on = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(consume_entry(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with no entry pending",
                                              o_checked));
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_kind", i_out_data.event_kind, want.event_kind);
                    check_field("dequeue_index", i_out_data.dequeue_index,
                                want.dequeue_index);
                    check_field("cycle_after", i_out_data.cycle_after, want.cycle_after);
                    check_field("code_out", i_out_data.code_out, want.code_out);
                    check_field("event_slot", i_out_data.event_slot, want.event_slot);
                    check_field("endpoint_out", i_out_data.endpoint_out, want.endpoint_out);
                    check_field("done_count", i_out_data.done_count, want.done_count);
                    check_field("report_valid", i_out_data.report_valid, want.report_valid);
                    check_field("report_length", i_out_data.report_length,
                                want.report_length);
                end
                o_checked++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/sv/tb_usb_event_ring_consumer.sv
`timescale 1ns / 1ps

module tb_usb_event_ring_consumer;

    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 10;

    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    uerc_pkg::t_in_beat             i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    uerc_pkg::t_out_beat            o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [uerc_pkg::CFG_IDX_W-1:0] i_cfg_index = uerc_pkg::REG_BLOCK_ENABLED;
    logic                           i_cfg_data  = 1'b0;

    int fail_count;
    int pending;
    int checked;

    int ring_pos     = 0;
    bit ring_cycle   = 1'b1;
    bit cur_en       = 1'b0;
    bit no_idle      = 1'b0;
    int entries_sent = 0;
    int wraps        = 0;
    int settings     = 0;
    int idle_cycles  = 0;

    int hold_left;
    int out_beats;
    bit out_quiet;

    bit phase_en  [PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 1};
    bit phase_rep [PHASES] = '{1, 0, 1, 1, 0, 0, 1, 0, 0, 1};

    usb_event_ring_consumer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    usb_event_ring_consumer_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
            out_beats = 0;
            out_quiet = 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            out_beats++;
            if (out_beats % 40 == 0) begin
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            hold_left = out_quiet ? 0 : $urandom_range(0, 15);
            i_out_stall <= (hold_left != 0);
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= (hold_left != 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a beat, %0d results pending",
                     idle_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic uerc_pkg::t_in_beat pack_entry(bit cyc, logic [5:0] typ,
                                                      logic [7:0] code, logic [7:0] slot,
                                                      logic [4:0] ep, logic [23:0] resid);
        uerc_pkg::t_in_beat e;
        e.entry_cycle     = cyc;
        e.entry_type      = typ;
        e.completion_code = code;
        e.slot_id         = slot;
        e.endpoint_index  = ep;
        e.residual_length = resid;
        return e;
    endfunction

    // mostly entries the ring will take; one in ten carries a stale cycle bit
    function automatic uerc_pkg::t_in_beat rand_entry();
        uerc_pkg::t_in_beat e;
        int                 pick;
        e.entry_cycle = ($urandom_range(0, 9) == 0) ? ~ring_cycle : ring_cycle;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            e.entry_type = uerc_pkg::TYPE_TRANSFER;
        end else if (pick == 6) begin
            e.entry_type = uerc_pkg::TYPE_COMMAND;
        end else if (pick == 7) begin
            e.entry_type = uerc_pkg::TYPE_PORT;
        end else begin
            e.entry_type = 6'($urandom_range(0, 63));
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            e.completion_code = uerc_pkg::CODE_SUCCESS;
        end else if (pick < 6) begin
            e.completion_code = uerc_pkg::CODE_SHORT;
        end else begin
            e.completion_code = 8'($urandom);
        end
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            e.slot_id = 8'($urandom);
        end else if (pick < 4) begin
            e.slot_id = 8'($urandom_range(0, 3));
        end else begin
            e.slot_id = 8'($urandom_range(0, uerc_pkg::SLOT_COUNT - 1));
        end
        e.endpoint_index = ($urandom_range(0, 7) == 0) ? 5'($urandom) :
                           5'($urandom_range(0, uerc_pkg::ENDPOINT_COUNT - 1));
        e.residual_length = 24'($urandom);
        return e;
    endfunction

    task automatic send_entry(uerc_pkg::t_in_beat e);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        entries_sent++;
        if (cur_en && e.entry_cycle == ring_cycle) begin
            ring_pos++;
            if (ring_pos >= uerc_pkg::RING_ENTRIES) begin
                ring_pos   = 0;
                ring_cycle = ~ring_cycle;
                wraps++;
            end
        end
    endtask

    task automatic write_regs(bit en, bit rep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= uerc_pkg::REG_BLOCK_ENABLED;
        i_cfg_data  <= en;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= uerc_pkg::REG_REPORT_ENABLE;
        i_cfg_data  <= rep;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_en = en;
        settings++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled out of reset: nothing consumed
        send_entry(pack_entry(1'b1, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd0, 5'd2, 24'h1));
        send_entry(pack_entry(1'b1, uerc_pkg::TYPE_COMMAND, uerc_pkg::CODE_SUCCESS,
                              8'd1, 5'd0, 24'h2));
        wait_idle();

        write_regs(1'b1, 1'b1);
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_COMMAND, 8'd0, 8'd0, 5'd0,
                              24'h0));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd0, 5'd2, 24'hFFFFFF));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd0, 5'd2, 24'h123456));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SHORT,
                              8'(uerc_pkg::SLOT_COUNT - 1),
                              5'(uerc_pkg::ENDPOINT_COUNT - 1), 24'h0));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd5, 5'd1, 24'h00AAAA));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, 8'd0, 8'd5, 5'd0,
                              24'h555555));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, 8'hFF,
                              8'(uerc_pkg::SLOT_COUNT), 5'd3, 24'hFFFFFF));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd3, 5'(uerc_pkg::ENDPOINT_COUNT), 24'h10));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SHORT,
                              8'hFF, 5'h1F, 24'hFFFFFF));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_PORT, 8'hFF, 8'hFF, 5'h1F,
                              24'hFFFFFF));
        send_entry(pack_entry(ring_cycle, 6'd0, uerc_pkg::CODE_SUCCESS, 8'd2, 5'd2, 24'h1));
        send_entry(pack_entry(ring_cycle, 6'h3F, uerc_pkg::CODE_SHORT, 8'd2, 5'd2, 24'h1));
        send_entry(pack_entry(~ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SUCCESS,
                              8'd1, 5'd3, 24'h777));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, 8'd2, 8'd1, 5'd3,
                              24'h888));
        send_entry(pack_entry(ring_cycle, uerc_pkg::TYPE_TRANSFER, uerc_pkg::CODE_SHORT,
                              8'(uerc_pkg::SLOT_COUNT - 1),
                              5'(uerc_pkg::ENDPOINT_COUNT - 1), 24'hABCDEF));
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_regs(phase_en[p], phase_rep[p]);
            n = phase_en[p] ? 170 : 40;
            for (int i = 0; i < n; i++) begin
                if (i % 40 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                send_entry(rand_entry());
            end
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        $display("sent %0d ring entries over %0d register settings, ring wrapped %0d times",
                 entries_sent, settings, wraps);
        $display("checked %0d result beats, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/uerc_pkg.sv
sv/uerc_ram.sv
sv/usb_event_ring_consumer.sv
tb/sv/usb_event_ring_consumer_chk.sv
tb/sv/tb_usb_event_ring_consumer.sv
